@@ rtl/core/stt_pkg.sv @@
// Shared types and codes for the session token table.
// Used by the table engine and the top level; depends on nothing.
package stt_pkg;

    localparam int TOKEN_W = 64;
    localparam int STAMP_W = 32;
    localparam int OUT_W   = 5;
    localparam int LIMIT_W = 5;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_TICK   = 2'd3;

    // status codes
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_FOUND    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_DUP      = 2'd3;

    // register indexes (byte address / 4)
    localparam logic REG_MAX_AGE = 1'b0;
    localparam logic REG_LIMIT   = 1'b1;

    localparam logic [STAMP_W-1:0] MAX_AGE_RST = 32'd1800;
    localparam logic [LIMIT_W-1:0] LIMIT_RST   = 5'd16;

    typedef struct packed {
        logic [STAMP_W-1:0] max_age;
        logic [LIMIT_W-1:0] limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [TOKEN_W-1:0] token;
    } req_t;

    typedef struct packed {
        logic [OUT_W-1:0] occupancy;
        logic [OUT_W-1:0] expired_count;
        logic             evicted;
        logic [1:0]       status;
    } res_t;

endpackage

@@ rtl/core/stt_ram.sv @@
// Simple dual-port entry memory: one write port, one read port with
// registered read data. No dependencies.
module stt_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/stt_engine.sv @@
// Table engine: ring buffer of entries in age order, scan, compaction and
// expiry sequencer around one entry memory. Depends on stt_pkg, stt_ram.
module stt_engine #(
    parameter int DEPTH      = 16,
    parameter int TOKEN_BITS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  stt_pkg::cfg_t cfg,
    input  logic          start,
    input  stt_pkg::req_t req,
    output logic          idle,
    output logic          res_valid,
    input  logic          res_ready,
    output stt_pkg::res_t res
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int EW = TOKEN_BITS + stt_pkg::STAMP_W;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_COMPACT = 3'd2;
    localparam logic [2:0] S_EXPIRE  = 3'd3;
    localparam logic [2:0] S_HOLD    = 3'd4;

    // logical slot (0 = oldest) to physical address
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] l);
        logic [SW-1:0] s;
        s = SW'(h) + SW'(l);
        if (s >= SW'(DEPTH))
        begin
            s = s - SW'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [stt_pkg::OUT_W-1:0] sat5(input logic [CW-1:0] v);
        if (32'(v) > 32'd31)
        begin
            return 5'd31;
        end
        return stt_pkg::OUT_W'(v);
    endfunction

    logic [2:0]                st_reg, st_next;
    logic [AW-1:0]             head_reg, head_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [31:0]               tick_reg, tick_next;
    logic [1:0]                op_reg, op_next;
    logic [TOKEN_BITS-1:0]     tok_reg, tok_next;
    logic [CW-1:0]             ridx_reg, ridx_next;
    logic [CW-1:0]             cidx_reg, cidx_next;
    logic                      pend_reg, pend_next;
    logic [CW-1:0]             exp_reg, exp_next;
    stt_pkg::res_t             res_reg, res_next;

    logic                      re, we;
    logic [AW-1:0]             raddr, waddr;
    logic [EW-1:0]             wdata, rdata;
    logic [TOKEN_BITS-1:0]     rd_tok;
    logic [31:0]               rd_stamp;
    logic [31:0]               lim32;
    logic [CW-1:0]             lim_eff;
    logic                      evict, issue, hit, age_ok;
    logic [CW-1:0]             cnt1;
    logic [AW-1:0]             head1;

    stt_ram #(.WIDTH(EW), .DEPTH(DEPTH), .AW(AW)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_tok   = rdata[TOKEN_BITS-1:0];
    assign rd_stamp = rdata[TOKEN_BITS +: 32];

    // effective session limit: zero acts as one, clamp to depth
    always_comb
    begin
        lim32 = 32'(cfg.limit);
        if (lim32 == 32'd0)
        begin
            lim32 = 32'd1;
        end
        else if (lim32 > 32'(DEPTH))
        begin
            lim32 = 32'(DEPTH);
        end
        lim_eff = lim32[CW-1:0];
    end

    assign evict  = (count_reg != '0) && (count_reg >= lim_eff);
    assign cnt1   = count_reg - CW'(evict);
    assign head1  = evict ? phys(head_reg, CW'(1)) : head_reg;
    assign issue  = ridx_reg < count_reg;
    assign hit    = pend_reg && (rd_tok == tok_reg);
    assign age_ok = (tick_reg - rd_stamp) >= cfg.max_age;

    // sequencer
    always_comb
    begin
        st_next    = st_reg;
        head_next  = head_reg;
        count_next = count_reg;
        tick_next  = tick_reg;
        op_next    = op_reg;
        tok_next   = tok_reg;
        ridx_next  = ridx_reg;
        cidx_next  = cidx_reg;
        pend_next  = pend_reg;
        exp_next   = exp_reg;
        res_next   = res_reg;
        re         = 1'b0;
        raddr      = head_reg;
        we         = 1'b0;
        waddr      = head_reg;
        wdata      = rdata;

        unique case (st_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next   = req.op;
                    tok_next  = req.token[TOKEN_BITS-1:0];
                    ridx_next = '0;
                    cidx_next = '0;
                    pend_next = 1'b0;
                    exp_next  = '0;
                    if (req.op == stt_pkg::OP_TICK)
                    begin
                        tick_next = tick_reg + 32'd1;
                        st_next   = S_EXPIRE;
                    end
                    else
                    begin
                        st_next = S_SCAN;
                    end
                end
            end

            // one read per cycle, each compare in the cycle after its read
            S_SCAN:
            begin
                res_next.evicted       = 1'b0;
                res_next.expired_count = '0;
                res_next.occupancy     = sat5(count_reg);
                if (hit)
                begin
                    unique case (op_reg)
                        stt_pkg::OP_INSERT:
                        begin
                            res_next.status = stt_pkg::ST_DUP;
                            st_next         = S_HOLD;
                        end
                        stt_pkg::OP_REMOVE:
                        begin
                            ridx_next = cidx_reg + CW'(1);
                            pend_next = 1'b0;
                            st_next   = S_COMPACT;
                        end
                        default:
                        begin
                            res_next.status = stt_pkg::ST_FOUND;
                            st_next         = S_HOLD;
                        end
                    endcase
                end
                else if (!issue)
                begin
                    if (op_reg == stt_pkg::OP_INSERT)
                    begin
                        // drop the oldest if at the limit, append at the tail
                        we                 = 1'b1;
                        waddr              = phys(head1, cnt1);
                        wdata              = {tick_reg, tok_reg};
                        head_next          = head1;
                        count_next         = cnt1 + CW'(1);
                        res_next.status    = stt_pkg::ST_DONE;
                        res_next.evicted   = evict;
                        res_next.occupancy = sat5(cnt1 + CW'(1));
                    end
                    else
                    begin
                        res_next.status = stt_pkg::ST_NOTFOUND;
                    end
                    st_next = S_HOLD;
                end
                else
                begin
                    re        = 1'b1;
                    raddr     = phys(head_reg, ridx_reg);
                    ridx_next = ridx_reg + CW'(1);
                    cidx_next = ridx_reg;
                    pend_next = 1'b1;
                end
            end

            // close the gap: copy slot l+1 into slot l, reads run ahead of writes
            S_COMPACT:
            begin
                if (pend_reg)
                begin
                    we    = 1'b1;
                    waddr = phys(head_reg, cidx_reg - CW'(1));
                    wdata = rdata;
                end
                if (issue)
                begin
                    re        = 1'b1;
                    raddr     = phys(head_reg, ridx_reg);
                    ridx_next = ridx_reg + CW'(1);
                    cidx_next = ridx_reg;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        count_next         = count_reg - CW'(1);
                        res_next.status    = stt_pkg::ST_FOUND;
                        res_next.occupancy = sat5(count_reg - CW'(1));
                        st_next            = S_HOLD;
                    end
                end
            end

            // expire from the oldest end, next head read issued speculatively
            S_EXPIRE:
            begin
                res_next.status        = stt_pkg::ST_DONE;
                res_next.evicted       = 1'b0;
                res_next.expired_count = sat5(exp_reg);
                res_next.occupancy     = sat5(count_reg);
                if (pend_reg)
                begin
                    if (age_ok)
                    begin
                        head_next  = phys(head_reg, CW'(1));
                        count_next = count_reg - CW'(1);
                        exp_next   = exp_reg + CW'(1);
                        if (count_reg > CW'(1))
                        begin
                            re        = 1'b1;
                            raddr     = phys(head_reg, CW'(1));
                            pend_next = 1'b1;
                        end
                        else
                        begin
                            pend_next = 1'b0;
                        end
                    end
                    else
                    begin
                        pend_next = 1'b0;
                        st_next   = S_HOLD;
                    end
                end
                else if (count_reg != '0)
                begin
                    re        = 1'b1;
                    raddr     = head_reg;
                    pend_next = 1'b1;
                end
                else
                begin
                    st_next = S_HOLD;
                end
            end

            S_HOLD:
            begin
                if (res_ready)
                begin
                    st_next = S_IDLE;
                end
            end

            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            tick_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            tick_reg  <= tick_next;
            pend_reg  <= pend_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        tok_reg  <= tok_next;
        ridx_reg <= ridx_next;
        cidx_reg <= cidx_next;
        exp_reg  <= exp_next;
        res_reg  <= res_next;
    end

    assign idle      = (st_reg == S_IDLE);
    assign res_valid = (st_reg == S_HOLD);
    assign res       = res_reg;

    a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && st_reg == S_IDLE) |=> (st_reg != S_IDLE))
        else $error("request accepted but engine stayed idle");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_IDLE || st_reg == S_HOLD) |-> !we)
        else $error("memory written outside an operation");

    a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_HOLD) |=> ($stable(count_reg) && $stable(head_reg)))
        else $error("table changed while a result waits");

    a_expire_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_EXPIRE && pend_reg) |-> (count_reg != '0))
        else $error("expiry read pending on an empty table");

endmodule

@@ rtl/core/session_token_table_with_aging.sv @@
// Top level of the session token table: APB registers, request channel,
// result output register. Depends on stt_pkg and stt_engine.
//
// Usage:
//   Requests arrive on s_axis (operation and token); each gives exactly one
//   result on m_axis (status, evicted flag, expired count, occupancy).
//   Configuration (max_age at 0x0, session_limit at 0x4) is written over APB
//   while no request is in flight.
// Request handling:
//   One request is worked at a time; s_axis_tready is high only while the
//   engine is idle. Insert, lookup and a missed remove scan the held
//   entries; a remove that hits also compacts the entries behind it, and a
//   tick reads and expires entries from the oldest end. Each is paced by
//   the single read port of the entry memory. The result shows on m_axis as
//   the engine turns idle.
// Reset:
//   Occupancy and tick counter clear, registers take their defaults. The
//   entry memory is not cleared; only occupied slots are ever read.
// Stall:
//   If m_axis_tready is low, one result waits in the output register and a
//   second one waits in the engine, which then refuses new requests.
module session_token_table_with_aging #(
    parameter int DEPTH      = 16,
    parameter int TOKEN_BITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // requests
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // [1:0] operation, [65:2] token, rest zero
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [1:0] status, [2] evicted,
                                        // [7:3] expired_count, [12:8] occupancy
);

    logic [31:0]   max_age_reg;
    logic [4:0]    limit_reg;
    stt_pkg::cfg_t cfg;
    stt_pkg::req_t req;
    stt_pkg::res_t res;
    logic          idle, res_valid, res_ready, start, cfg_wr;
    logic          m_valid_reg, m_valid_next;
    stt_pkg::res_t m_data_reg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_age_reg <= stt_pkg::MAX_AGE_RST;
            limit_reg   <= stt_pkg::LIMIT_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == stt_pkg::REG_MAX_AGE)
            begin
                max_age_reg <= pwdata;
            end
            else
            begin
                limit_reg <= pwdata[4:0];
            end
        end
    end

    assign prdata = (paddr[2] == stt_pkg::REG_LIMIT) ? {27'd0, limit_reg} : max_age_reg;

    assign cfg.max_age = max_age_reg;
    assign cfg.limit   = limit_reg;

    // request channel
    assign req.op        = s_axis_tdata[1:0];
    assign req.token     = s_axis_tdata[65:2];
    assign s_axis_tready = idle;
    assign start         = s_axis_tvalid && idle;

    stt_engine #(.DEPTH(DEPTH), .TOKEN_BITS(TOKEN_BITS)) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .start     (start),
        .req       (req),
        .idle      (idle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // result output register
    assign res_ready = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_data_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {3'd0, m_data_reg};

endmodule
